// ===== src/halfedge_twin_matcher_assert.svh =====
// assertion macros shared by the halfedge twin matcher sources
`ifndef HALFEDGE_TWIN_MATCHER_ASSERT_SVH
`define HALFEDGE_TWIN_MATCHER_ASSERT_SVH

// condition must never hold outside reset
`define HETM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define HETM_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/hetm_pkg.sv =====
// ----------------------------------------------------------------------------
// hetm_pkg
// types shared by the halfedge twin matcher front, back and top level
// ----------------------------------------------------------------------------
package hetm_pkg;

  localparam int VERT_W = 16;
  localparam int OUT_IDX_W = 16;
  localparam int KEY_W = 2 * VERT_W;

  // one triangle as handed from front to back
  typedef struct packed {
    logic [2:0][OUT_IDX_W-1:0] hidx;
    logic [2:0][VERT_W-1:0]    vtx;
    logic [2:0]                ovf;
    logic                      start;
  } tri_cmd_t;

  // one edge table entry
  typedef struct packed {
    logic                 valid;
    logic                 paired;
    logic [OUT_IDX_W-1:0] first;
    logic [KEY_W-1:0]     key;
  } edge_word_t;

  // one halfedge record
  typedef struct packed {
    logic                 last;
    logic                 index_overflow;
    logic                 table_full;
    logic                 non_manifold;
    logic                 twin_found;
    logic [OUT_IDX_W-1:0] twin_index;
    logic [OUT_IDX_W-1:0] prev_index;
    logic [OUT_IDX_W-1:0] next_index;
    logic [VERT_W-1:0]    start_vertex;
    logic [OUT_IDX_W-1:0] halfedge_index;
  } he_rec_t;

  typedef enum logic [3:0] {
    ST_SWEEP = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_CMP   = 4'b1000
  } back_state_t;

endpackage

// ===== src/hetm_ram.sv =====
// ----------------------------------------------------------------------------
// hetm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hetm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/hetm_front.sv =====
// ----------------------------------------------------------------------------
// hetm_front
// accepts triangles, assigns halfedge indices, queues them for the back end
// ----------------------------------------------------------------------------
module hetm_front #(
  parameter int INDEX_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0][15:0]    in_vtx,
  input  logic                in_start,
  output logic                q_valid,
  output hetm_pkg::tri_cmd_t  q_cmd,
  input  logic                q_pop
);

`include "halfedge_twin_matcher_assert.svh"

  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  logic [INDEX_BITS-1:0] counter;
  logic [INDEX_BITS-1:0] counter_next;
  logic [INDEX_BITS-1:0] c0, c1, c2;
  hetm_pkg::tri_cmd_t    cmd_in;
  hetm_pkg::tri_cmd_t    qmem [2];
  logic                  wptr, rptr;
  logic [1:0]            qcnt;
  logic                  push;

  function automatic logic [hetm_pkg::OUT_IDX_W-1:0] low_idx(input logic [INDEX_BITS-1:0] v);
    logic [hetm_pkg::OUT_IDX_W+INDEX_BITS-1:0] ext;
    ext = {{hetm_pkg::OUT_IDX_W{1'b0}}, v};
    return ext[hetm_pkg::OUT_IDX_W-1:0];
  endfunction

  // saturating index chain
  always_comb begin
    c0 = in_start ? '0 : counter;
    c1 = (c0 == IDX_MAX) ? c0 : c0 + 1'b1;
    c2 = (c1 == IDX_MAX) ? c1 : c1 + 1'b1;
    counter_next = (c2 == IDX_MAX) ? c2 : c2 + 1'b1;
    cmd_in.hidx[0] = low_idx(c0);
    cmd_in.hidx[1] = low_idx(c1);
    cmd_in.hidx[2] = low_idx(c2);
    cmd_in.ovf = {c2 == IDX_MAX, c1 == IDX_MAX, c0 == IDX_MAX};
    cmd_in.vtx = in_vtx;
    cmd_in.start = in_start;
  end

  assign in_ready = (qcnt != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (qcnt != 2'd0);
  assign q_cmd = qmem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wptr] <= cmd_in;
    end
    if (rst) begin
      counter <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
      qcnt <= 2'd0;
    end else begin
      if (push) begin
        counter <= counter_next;
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      qcnt <= qcnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `HETM_NEVER(a_pop_empty, q_pop && !q_valid, "queue popped while empty")
  `HETM_NEVER(a_overfill, qcnt == 2'd3, "queue count out of range")
  `HETM_IMPLIES(a_start_idx, push && in_start, cmd_in.hidx[0] == '0, "start did not restart index")

endmodule

// ===== src/hetm_back.sv =====
// ----------------------------------------------------------------------------
// hetm_back
// looks up each triangle edge in a probed hash table and emits records
// ----------------------------------------------------------------------------
module hetm_back #(
  parameter int EDGE_TABLE_ENTRIES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  hetm_pkg::tri_cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output hetm_pkg::he_rec_t  out_rec
);

`include "halfedge_twin_matcher_assert.svh"

  localparam int AW = $clog2(EDGE_TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(EDGE_TABLE_ENTRIES - 1);
  localparam int WW = $bits(hetm_pkg::edge_word_t);

  hetm_pkg::back_state_t state;
  logic [1:0]            k;
  logic [AW-1:0]         addr;
  logic [AW-1:0]         probes;
  logic                  cleared;

  hetm_pkg::edge_word_t rd_word, wr_word;
  logic [WW-1:0]        rd_raw;
  logic                 we;

  logic [1:0]  ksel, kn1, kn2, cn1;
  logic [15:0] ea, eb, sa, sb, lo, hi, slo, shi, h16;
  logic [31:0] key;
  logic [33:0] prod;
  logic [AW-1:0] hash_sel;
  logic        ofree, hit, empty_slot, give_up, emit;
  hetm_pkg::he_rec_t rec;

  function automatic logic [1:0] nxt(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  // current edge
  always_comb begin
    kn1 = nxt(k);
    kn2 = nxt(kn1);
    ea = q_cmd.vtx[k];
    eb = q_cmd.vtx[kn1];
    lo = (ea < eb) ? ea : eb;
    hi = (ea < eb) ? eb : ea;
    key = {lo, hi};
  end

  // edge whose probe starts next: first edge from idle, else the following one
  always_comb begin
    ksel = (state == hetm_pkg::ST_CMP) ? kn1 : 2'd0;
    cn1 = nxt(ksel);
    sa = q_cmd.vtx[ksel];
    sb = q_cmd.vtx[cn1];
    slo = (sa < sb) ? sa : sb;
    shi = (sa < sb) ? sb : sa;
    h16 = shi ^ {slo[7:0], slo[15:8]};
    prod = 34'(h16) * 34'(EDGE_TABLE_ENTRIES);
    hash_sel = prod[16 +: AW];
  end

  assign rd_word = hetm_pkg::edge_word_t'(rd_raw);
  assign ofree = !out_valid || out_ready;
  assign hit = rd_word.valid && (rd_word.key == key);
  assign empty_slot = !rd_word.valid;
  assign give_up = !hit && !empty_slot && (probes == LAST_SLOT);
  assign emit = (state == hetm_pkg::ST_CMP) && ofree && (hit || empty_slot || give_up);
  assign q_pop = emit && (k == 2'd2);

  always_comb begin
    we = 1'b0;
    wr_word = '0;
    if (state == hetm_pkg::ST_SWEEP) begin
      we = 1'b1;
    end else if (emit && hit && !rd_word.paired) begin
      we = 1'b1;
      wr_word = rd_word;
      wr_word.paired = 1'b1;
    end else if (emit && empty_slot) begin
      we = 1'b1;
      wr_word.valid = 1'b1;
      wr_word.first = q_cmd.hidx[k];
      wr_word.key = key;
    end
  end

  always_comb begin
    rec.halfedge_index = q_cmd.hidx[k];
    rec.start_vertex = ea;
    rec.next_index = q_cmd.hidx[kn1];
    rec.prev_index = q_cmd.hidx[kn2];
    rec.twin_index = hit ? rd_word.first : '0;
    rec.twin_found = hit;
    rec.non_manifold = hit && rd_word.paired;
    rec.table_full = give_up;
    rec.index_overflow = q_cmd.ovf[k];
    rec.last = (k == 2'd2);
  end

  hetm_ram #(.WIDTH(WW), .DEPTH(EDGE_TABLE_ENTRIES)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata(wr_word),
    .raddr(addr),
    .rdata(rd_raw)
  );

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rec <= rec;
    end
    if (rst) begin
      state <= hetm_pkg::ST_SWEEP;
      addr <= '0;
      probes <= '0;
      k <= 2'd0;
      cleared <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        hetm_pkg::ST_SWEEP: begin
          if (addr == LAST_SLOT) begin
            cleared <= 1'b1;
            state <= hetm_pkg::ST_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        hetm_pkg::ST_IDLE: begin
          if (q_valid) begin
            if (q_cmd.start && !cleared) begin
              addr <= '0;
              state <= hetm_pkg::ST_SWEEP;
            end else begin
              k <= 2'd0;
              addr <= hash_sel;
              probes <= '0;
              state <= hetm_pkg::ST_LOOK;
            end
          end
        end
        hetm_pkg::ST_LOOK: begin
          state <= hetm_pkg::ST_CMP;
        end
        hetm_pkg::ST_CMP: begin
          if (emit) begin
            if (k == 2'd2) begin
              cleared <= 1'b0;
              state <= hetm_pkg::ST_IDLE;
            end else begin
              k <= kn1;
              addr <= hash_sel;
              probes <= '0;
              state <= hetm_pkg::ST_LOOK;
            end
          end else if (ofree) begin
            // slot taken by another edge: linear probe
            probes <= probes + 1'b1;
            addr <= (addr == LAST_SLOT) ? '0 : addr + 1'b1;
            state <= hetm_pkg::ST_LOOK;
          end
        end
        default: begin
          state <= hetm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `HETM_IMPLIES(a_nonman_twin, emit && rec.non_manifold, rec.twin_found, "non-manifold without twin")
  `HETM_IMPLIES(a_full_twin, emit && rec.table_full, !rec.twin_found, "full edge reported a twin")
  `HETM_IMPLIES(a_sweep_quiet, state == hetm_pkg::ST_SWEEP, !q_pop && !emit, "record during sweep")

endmodule

// ===== src/halfedge_twin_matcher.sv =====
// back end: the edges of a triangle are looked up one after another through the single read
//   port of the edge table; each hash probe is one ram read and one compare, a slot taken by
//   another edge adds a probe, and the next triangle is taken after the last record is emitted
// a start_of_mesh triangle first runs a clearing pass unless none ended since the last pass
// reset: synchronous; the edge table is cleared by the same pass over every entry,
//   during which up to two triangles queue in the front end and nothing is emitted
// ----------------------------------------------------------------------------
// halfedge_twin_matcher
// numbers triangle halfedges and pairs them with earlier halfedges on the
// same undirected edge
// ----------------------------------------------------------------------------
module halfedge_twin_matcher #(
  parameter int EDGE_TABLE_ENTRIES = 4096,
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // triangle stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // vertex_a, vertex_b, vertex_c
  input  logic        s_axis_tuser,   // start_of_mesh
  // halfedge record stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // halfedge_index, start_vertex, next_index, prev_index,
                                      // twin_index, twin_found, non_manifold, table_full,
                                      // index_overflow, zero pad
  output logic        m_axis_tlast    // last_of_triangle
);

  // front to back queue
  logic               q_valid;
  logic               q_pop;
  hetm_pkg::tri_cmd_t q_cmd;
  hetm_pkg::he_rec_t  rec;
  logic [2:0][15:0]   vtx;

  assign vtx = s_axis_tdata;

  // front: takes triangle transfers, hands out three halfedge indices each
  hetm_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_vtx  (vtx),
    .in_start(s_axis_tuser),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // back: edge table lookup, insert and record output register
  hetm_back #(.EDGE_TABLE_ENTRIES(EDGE_TABLE_ENTRIES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_rec  (rec)
  );

  // record packing, first field in the low bits
  assign m_axis_tdata = {4'b0, rec.index_overflow, rec.table_full, rec.non_manifold,
                         rec.twin_found, rec.twin_index, rec.prev_index, rec.next_index,
                         rec.start_vertex, rec.halfedge_index};
  assign m_axis_tlast = rec.last;

endmodule

// ===== bench/tb_halfedge_twin_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_halfedge_twin_matcher
// self-checking bench: triangles go in on the slave stream, every halfedge
// record coming out is checked field by field against an in-bench model of
// halfedge numbering, the undirected edge table, twin pairing and saturation
// ----------------------------------------------------------------------------
module tb_halfedge_twin_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_MAX = 65535;
  // cycles with no transfer on either side before giving up; covers the clearing
  // pass and long probe chains in the edge table
  localparam int STALL_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic        start;
    logic [15:0] vc;
    logic [15:0] vb;
    logic [15:0] va;
  } tri_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // vertex_a, vertex_b, vertex_c
  logic        s_axis_tuser = 1'b0; // start_of_mesh
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // halfedge_index, start_vertex, next_index, prev_index,
                                    // twin_index, twin_found, non_manifold, table_full,
                                    // index_overflow, zero pad
  logic        m_axis_tlast;        // last_of_triangle

  halfedge_twin_matcher u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  // triangles waiting to be sent, records waiting to come out
  tri_item_t          pending_tris[$];
  hetm_pkg::he_rec_t  expected_recs[$];

  // idle percentages of sender and receiver
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // model state: halfedge counter and the undirected edge table
  int unsigned  he_counter = 0;
  int unsigned  stored_edges = 0;
  logic [15:0]  edge_first[int unsigned];
  bit           edge_paired[int unsigned];

  // number one triangle's halfedges and pair them through the edge table
  task automatic number_triangle(input tri_item_t t);
    logic [15:0] v[3];
    logic [15:0] h[3];
    bit          ovf[3];
    int unsigned key;
    logic [15:0] lo, hi;
    hetm_pkg::he_rec_t r;
    v[0] = t.va; v[1] = t.vb; v[2] = t.vc;
    if (t.start) begin
      edge_first.delete();
      edge_paired.delete();
      stored_edges = 0;
      he_counter = 0;
    end
    for (int k = 0; k < 3; k++) begin
      h[k] = he_counter[15:0];
      ovf[k] = (he_counter >= IDX_MAX);
      if (!ovf[k]) he_counter++;
    end
    for (int k = 0; k < 3; k++) begin
      lo = (v[k] < v[(k+1)%3]) ? v[k] : v[(k+1)%3];
      hi = (v[k] < v[(k+1)%3]) ? v[(k+1)%3] : v[k];
      key = {lo, hi};
      r = '0;
      if (edge_first.exists(key)) begin
        r.twin_found = 1'b1;
        r.twin_index = edge_first[key];
        // third use keeps the entry as is
        if (edge_paired[key]) r.non_manifold = 1'b1;
        else edge_paired[key] = 1'b1;
      end else if (stored_edges < TABLE_ENTRIES) begin
        edge_first[key] = h[k];
        edge_paired[key] = 1'b0;
        stored_edges++;
      end else begin
        r.table_full = 1'b1;
      end
      r.halfedge_index = h[k];
      r.start_vertex   = v[k];
      r.next_index     = h[(k+1)%3];
      r.prev_index     = h[(k+2)%3];
      r.index_overflow = ovf[k];
      r.last           = (k == 2);
      expected_recs = {expected_recs, r};
    end
  endtask

  // sender: keeps tvalid up until the transfer, then loads the next triangle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_tris.size() != 0 && $urandom_range(99) >= send_idle) begin
        tri_item_t t;
        t = pending_tris.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t.vc, t.vb, t.va};
        s_axis_tuser  <= t.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // monitor: predict on every input transfer, check every output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        number_triangle({s_axis_tuser, s_axis_tdata});
      if (m_axis_tvalid && m_axis_tready) begin
        hetm_pkg::he_rec_t got, want;
        got.halfedge_index = m_axis_tdata[15:0];
        got.start_vertex   = m_axis_tdata[31:16];
        got.next_index     = m_axis_tdata[47:32];
        got.prev_index     = m_axis_tdata[63:48];
        got.twin_index     = m_axis_tdata[79:64];
        got.twin_found     = m_axis_tdata[80];
        got.non_manifold   = m_axis_tdata[81];
        got.table_full     = m_axis_tdata[82];
        got.index_overflow = m_axis_tdata[83];
        got.last           = m_axis_tlast;
        if (expected_recs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected record %h", got);
        end else begin
          want = expected_recs.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("record mismatch: expected %h got %h", want, got);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic tri_item_t mk_tri(input int a, input int b, input int c, input bit st);
    tri_item_t t;
    t.va = 16'(a); t.vb = 16'(b); t.vc = 16'(c); t.start = st;
    return t;
  endfunction

  // mostly small vertex sets so edges pair up, some full range values
  function automatic logic [15:0] rand_vertex();
    if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
    return 16'($urandom_range(15));
  endfunction

  task automatic queue_tri(input tri_item_t t);
    pending_tris = {pending_tris, t};
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++)
      queue_tri(mk_tri(rand_vertex(), rand_vertex(), rand_vertex(),
                       $urandom_range(99) < 3));
  endtask

  task automatic drain();
    wait (pending_tris.size() == 0 && !s_axis_tvalid);
    wait (expected_recs.size() == 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, twins, non-manifold use, degenerate, mid-run start
    queue_tri(mk_tri(0, 0, 0, 1));
    queue_tri(mk_tri(65535, 65535, 65535, 0));
    queue_tri(mk_tri(0, 65535, 1, 0));
    queue_tri(mk_tri(65535, 0, 2, 0));        // twin of the edge between vertices 0 and 65535
    queue_tri(mk_tri(0, 65535, 3, 0));        // third use of the same edge
    queue_tri(mk_tri(16'haaaa, 16'h5555, 16'h00ff, 0));
    queue_tri(mk_tri(16'h5555, 16'haaaa, 16'hff00, 0));
    queue_tri(mk_tri(7, 7, 8, 0));            // repeated corner
    queue_tri(mk_tri(9, 10, 9, 0));           // edges pair within a triangle
    queue_tri(mk_tri(1, 2, 3, 1));            // start mid-run
    queue_tri(mk_tri(3, 2, 4, 0));
    queue_tri(mk_tri(2, 3, 5, 0));
    queue_tri(mk_tri(4, 3, 1, 0));
    queue_tri(mk_tri(0, 65535, 1, 0));
    drain();

    // random, three backpressure phases
    send_idle = 23; recv_idle = 83;
    add_random(170);
    drain();
    send_idle = 83; recv_idle = 23;
    add_random(170);
    drain();
    send_idle = 0; recv_idle = 0;
    add_random(160);

    queue_tri(mk_tri(5, 6, 7, 1));
    queue_tri(mk_tri(7, 6, 8, 0));
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_recs.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
